/* sv/pdh_pkg.sv */
// Package for the pair distance histogram: widths, codes, item and config types, wrap function.
package pdh_pkg;

	localparam int COORD_W        = 20;
	localparam int MAG_W          = 21;
	localparam int SUM_W          = 44;
	localparam int SUM4_W         = 46;
	localparam int ROOT_W         = 23;
	localparam int REM_W          = 27;
	localparam int RB_W           = 8;
	localparam int HB_W           = 8;
	localparam int OUT_W          = 32;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_W          = 20;
	localparam int NBINS_W        = 9;
	localparam int MAX_BINS_DEF   = 256;
	localparam int COUNT_BITS_DEF = 32;

	localparam logic [CFG_W-1:0]   BOX_RST      = 20'hFFFFF;
	localparam logic [CFG_W-1:0]   BIN_SIZE_RST = 20'd1024;
	localparam logic [NBINS_W-1:0] NUM_BINS_RST = 9'd256;

	typedef enum logic [1:0] {
		KIND_PAIR = 2'd0,
		KIND_SKIP = 2'd1,
		KIND_READ = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_X    = 3'd0,
		REG_BOX_Y    = 3'd1,
		REG_BOX_Z    = 3'd2,
		REG_BIN_SIZE = 3'd3,
		REG_NUM_BINS = 3'd4,
		REG_SLAB_LO  = 3'd5,
		REG_SLAB_HI  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0]   box_x;
		logic [CFG_W-1:0]   box_y;
		logic [CFG_W-1:0]   box_z;
		logic [CFG_W-1:0]   bin_size;
		logic [NBINS_W-1:0] num_bins;
		logic [CFG_W-1:0]   slab_lo;
		logic [CFG_W-1:0]   slab_hi;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic              cnt;
		logic [RB_W-1:0]   rb;
		logic [MAG_W-1:0]  ax;
		logic [MAG_W-1:0]  ay;
		logic [MAG_W-1:0]  az;
	} item_t;

	// Minimum-image magnitude of o - c for one axis; a zero box leaves it unwrapped
	function automatic logic [MAG_W-1:0] wrap_mag(input logic [COORD_W-1:0] c,
		input logic [COORD_W-1:0] o, input logic [COORD_W-1:0] b);
		logic signed [COORD_W+2:0] d;
		logic signed [COORD_W+2:0] bb;
		d  = $signed({3'b000, o}) - $signed({3'b000, c});
		bb = $signed({3'b000, b});
		if ((d <<< 1) < -bb) begin
			d = d + bb;
		end else if ((d <<< 1) >= bb) begin
			d = d - bb;
		end
		if (d < 0) begin
			d = -d;
		end
		return d[MAG_W-1:0];
	endfunction

endpackage

/* sv/pdh_in_if.sv */
// Input channel interface: one pair or read request per word.
interface pdh_in_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [pdh_pkg::COORD_W-1:0] center_x;
	logic [pdh_pkg::COORD_W-1:0] center_y;
	logic [pdh_pkg::COORD_W-1:0] center_z;
	logic [pdh_pkg::COORD_W-1:0] other_x;
	logic [pdh_pkg::COORD_W-1:0] other_y;
	logic [pdh_pkg::COORD_W-1:0] other_z;
	logic                        count_center;
	logic [pdh_pkg::RB_W-1:0]    read_bin;

	modport source(output valid, mode, center_x, center_y, center_z, other_x, other_y,
		other_z, count_center, read_bin, input ready);
	modport sink(input valid, mode, center_x, center_y, center_z, other_x, other_y,
		other_z, count_center, read_bin, output ready);
endinterface

/* sv/pdh_out_if.sv */
// Output channel interface: one result word per input word.
interface pdh_out_if;
	logic                      valid;
	logic                      ready;
	logic                      hit;
	logic [pdh_pkg::HB_W-1:0]  hit_bin;
	logic [pdh_pkg::OUT_W-1:0] bin_count;
	logic [pdh_pkg::OUT_W-1:0] center_total;

	modport source(output valid, hit, hit_bin, bin_count, center_total, input ready);
	modport sink(input valid, hit, hit_bin, bin_count, center_total, output ready);
endinterface

/* sv/pdh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pdh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/pdh_front.sv */
// Front end: accepts input words, applies the slab filter, wraps distances, queues items.
module pdh_front import pdh_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	pdh_in_if.sink in,
	input  cfg_t   cfg,
	input  logic   open,
	output logic   q_valid,
	output item_t  q_item,
	input  logic   q_pop
);
	localparam int QD = 2;

	item_t      ent_q [QD];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] n_q;
	logic       push;
	item_t      cls;
	logic [CFG_W-1:0] lo;
	logic [CFG_W-1:0] hi;
	logic       pass;

	// classify the incoming word
	always_comb begin
		lo   = (cfg.slab_lo < cfg.slab_hi) ? cfg.slab_lo : cfg.slab_hi;
		hi   = (cfg.slab_lo < cfg.slab_hi) ? cfg.slab_hi : cfg.slab_lo;
		pass = (cfg.slab_hi == '0) || (in.center_x >= lo && in.center_x < hi);
		cls.kind = in.mode ? KIND_READ : (pass ? KIND_PAIR : KIND_SKIP);
		cls.cnt  = in.count_center;
		cls.rb   = in.read_bin;
		cls.ax   = wrap_mag(in.center_x, in.other_x, cfg.box_x);
		cls.ay   = wrap_mag(in.center_y, in.other_y, cfg.box_y);
		cls.az   = wrap_mag(in.center_z, in.other_z, cfg.box_z);
	end

	assign in.ready = open && (n_q != 2'(QD));
	assign push     = in.valid && in.ready;
	assign q_valid  = (n_q != 2'd0);
	assign q_item   = ent_q[rp_q];

	// hold queue entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= cls;
		end
	end

	// advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			n_q  <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			n_q <= n_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

/* sv/pdh_back.sv */
// Back end: bin memory clear, squares, root, bin division, histogram update and result register.
module pdh_back import pdh_pkg::*; #(
	parameter int MAX_BINS   = MAX_BINS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_valid,
	input  item_t      q_item,
	output logic       q_pop,
	output logic       open,
	pdh_out_if.source  out
);
	localparam int AW   = $clog2(MAX_BINS);
	localparam int NBW  = $clog2(MAX_BINS + 1);
	localparam int LIMW = CFG_W + NBW + 1;
	localparam int DVW  = ROOT_W + 1 + AW;
	localparam int ITW  = 5;
	localparam int PW   = 2 * MAG_W;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_SQ    = 7'b0000100,
		S_SQRT  = 7'b0001000,
		S_DIV   = 7'b0010000,
		S_RD    = 7'b0100000,
		S_UPD   = 7'b1000000
	} state_t;

	state_t                state_q;
	item_t                 item_q;
	logic [COUNT_BITS-1:0] ctr_q;
	logic [LIMW-1:0]       lim_q;
	logic [CFG_W-1:0]      bs_q;
	logic [NBW-1:0]        nb_q;
	logic [1:0]            sel_q;
	logic [PW-1:0]         prod_q;
	logic [SUM_W-1:0]      acc_q;
	logic [SUM4_W-1:0]     v_q;
	logic [REM_W-1:0]      rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [ITW-1:0]        it_q;
	logic [DVW-1:0]        drem_q;
	logic [DVW-1:0]        dden_q;
	logic [AW-1:0]         quo_q;
	logic [AW-1:0]         addr_q;
	logic                  ov_q;
	logic                  o_hit_q;
	logic [HB_W-1:0]       o_bin_q;
	logic [OUT_W-1:0]      o_cnt_q;
	logic [OUT_W-1:0]      o_tot_q;

	logic [CFG_W-1:0]      bs_c;
	logic [NBW-1:0]        nb_c;
	logic [MAG_W-1:0]      mag_c;
	logic [SUM_W-1:0]      sum_c;
	logic [REM_W-1:0]      rem_n;
	logic [REM_W-1:0]      trial;
	logic                  sq_ge;
	logic [ROOT_W-1:0]     root_n;
	logic                  dv_ge;
	logic [AW-1:0]         quo_n;
	logic [AW-1:0]         idx_c;
	logic [AW+RB_W-1:0]    rbx;
	logic                  rb_ok;
	logic [AW+HB_W-1:0]    hbx;
	logic                  ram_we;
	logic [COUNT_BITS-1:0] ram_wd;
	logic [COUNT_BITS-1:0] ram_rd;
	logic                  out_load;
	logic                  o_hit_c;
	logic [HB_W-1:0]       o_bin_c;
	logic [OUT_W-1:0]      o_cnt_c;

	function automatic logic [OUT_W-1:0] sat32(input logic [COUNT_BITS-1:0] v);
		logic [COUNT_BITS+OUT_W-1:0] e;
		e = {{OUT_W{1'b0}}, v};
		return (|e[COUNT_BITS+OUT_W-1:OUT_W]) ? '1 : e[OUT_W-1:0];
	endfunction

	// effective bin size and bin count
	always_comb begin
		bs_c = (cfg.bin_size == '0) ? CFG_W'(1) : cfg.bin_size;
		if (cfg.num_bins == '0) begin
			nb_c = NBW'(1);
		end else if (int'(cfg.num_bins) > MAX_BINS) begin
			nb_c = NBW'(MAX_BINS);
		end else begin
			nb_c = NBW'(cfg.num_bins);
		end
	end

	// one root digit per cycle
	always_comb begin
		rem_n  = {rem_q[REM_W-3:0], v_q[SUM4_W-1:SUM4_W-2]};
		trial  = REM_W'({root_q, 2'b01});
		sq_ge  = (rem_n >= trial);
		root_n = {root_q[ROOT_W-2:0], sq_ge};
	end

	// one quotient bit per cycle, clamp to the last bin in use
	always_comb begin
		dv_ge = (drem_q >= dden_q);
		quo_n = AW'({quo_q, dv_ge});
		idx_c = (quo_n >= nb_q) ? AW'(nb_q - 1'b1) : quo_n;
	end

	always_comb begin
		case (sel_q)
			2'd0:    mag_c = item_q.ax;
			2'd1:    mag_c = item_q.ay;
			default: mag_c = item_q.az;
		endcase
		sum_c = acc_q + SUM_W'(prod_q);
		rbx   = {{AW{1'b0}}, q_item.rb};
		rb_ok = (rbx < MAX_BINS);
		hbx   = {{HB_W{1'b0}}, addr_q};
	end

	assign open  = (state_q != S_CLEAR);
	assign q_pop = (state_q == S_IDLE) && q_valid && (!ov_q || out.ready);

	// RAM write and result selection
	always_comb begin
		ram_we   = 1'b0;
		ram_wd   = '0;
		out_load = 1'b0;
		o_hit_c  = 1'b0;
		o_bin_c  = '0;
		o_cnt_c  = '0;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_IDLE: begin
				if (q_pop && (q_item.kind == KIND_SKIP ||
					(q_item.kind == KIND_READ && !rb_ok))) begin
					out_load = 1'b1;
				end
			end
			S_SQRT: begin
				if (it_q == '0 && !(LIMW'(root_n) < lim_q)) begin
					out_load = 1'b1;
				end
			end
			S_UPD: begin
				out_load = 1'b1;
				if (item_q.kind == KIND_READ) begin
					o_cnt_c = sat32(ram_rd);
				end else begin
					ram_we  = (ram_rd != '1);
					ram_wd  = ram_rd + 1'b1;
					o_hit_c = 1'b1;
					o_bin_c = hbx[HB_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// sequence the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			addr_q  <= '0;
			ctr_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (out.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (addr_q == AW'(MAX_BINS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (q_pop) begin
						if (q_item.kind == KIND_PAIR) begin
							state_q <= S_SQ;
							if (q_item.cnt && ctr_q != '1) begin
								ctr_q <= ctr_q + 1'b1;
							end
						end else if (q_item.kind == KIND_READ && rb_ok) begin
							addr_q  <= rbx[AW-1:0];
							state_q <= S_RD;
						end
					end
				end
				S_SQ: begin
					if (sel_q == 2'd3) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (it_q == '0) begin
						state_q <= (LIMW'(root_n) < lim_q) ? S_DIV : S_IDLE;
					end
				end
				S_DIV: begin
					if (it_q == '0) begin
						addr_q  <= idx_c;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mag_c * mag_c;
		if (q_pop) begin
			item_q <= q_item;
			bs_q   <= bs_c;
			nb_q   <= nb_c;
			lim_q  <= LIMW'(bs_c) * LIMW'({nb_c, 1'b0} - 1'b1);
			sel_q  <= 2'd0;
			acc_q  <= '0;
		end
		if (state_q == S_SQ) begin
			sel_q <= sel_q + 1'b1;
			if (sel_q != 2'd0) begin
				acc_q <= sum_c;
			end
			if (sel_q == 2'd3) begin
				v_q    <= {sum_c, 2'b00};
				rem_q  <= '0;
				root_q <= '0;
				it_q   <= ITW'(ROOT_W - 1);
			end
		end
		if (state_q == S_SQRT) begin
			v_q    <= {v_q[SUM4_W-3:0], 2'b00};
			rem_q  <= sq_ge ? (rem_n - trial) : rem_n;
			root_q <= root_n;
			it_q   <= it_q - 1'b1;
			if (it_q == '0) begin
				drem_q <= DVW'(root_n) + DVW'(bs_q);
				dden_q <= DVW'({bs_q, 1'b0}) << (AW - 1);
				quo_q  <= '0;
				it_q   <= ITW'(AW - 1);
			end
		end
		if (state_q == S_DIV) begin
			drem_q <= dv_ge ? (drem_q - dden_q) : drem_q;
			dden_q <= dden_q >> 1;
			quo_q  <= quo_n;
			it_q   <= it_q - 1'b1;
		end
		if (out_load) begin
			o_hit_q <= o_hit_c;
			o_bin_q <= o_bin_c;
			o_cnt_q <= o_cnt_c;
			o_tot_q <= sat32(ctr_q);
		end
	end

	pdh_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(MAX_BINS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_q),
		.wdata(ram_wd),
		.raddr(addr_q),
		.rdata(ram_rd)
	);

	assign out.valid        = ov_q;
	assign out.hit          = o_hit_q;
	assign out.hit_bin      = o_bin_q;
	assign out.bin_count    = o_cnt_q;
	assign out.center_total = o_tot_q;

`ifndef ASSERT_OFF
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == S_IDLE))
		else $error("item taken from queue while back end busy");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!ov_q || out.ready))
		else $error("result register overwritten before it was taken");
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !q_pop)
		else $error("item taken during histogram clear");
	a_upd_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> ($past(state_q) == S_RD))
		else $error("bin update without a preceding read");
`endif
endmodule

/* sv/pair_distance_histogram.sv */
// Top level of the pair distance histogram: config registers, front end and back end.
//
// Each input word is either an atom pair to bin or a request to read one bin count, and
// each gives exactly one result word, in order. The front end takes a word per cycle into
// a two-entry queue while the queue has room; the back end then works one item at a time: a
// binned pair goes through the shared squaring multiplier, the bit-serial square root, the
// bin divider and a read-modify-write of the bin memory; a pair that misses the cutoff
// skips the divider and the memory, a bin read only reads the bin memory, and a pair
// dropped by the slab filter gets its result word straight from the idle state. After reset
// the back end sweeps the bin memory to zero, one entry per cycle; input ready stays low
// until the sweep ends, while configuration writes are taken at once. Write configuration only while the block is idle.
module pair_distance_histogram import pdh_pkg::*; #(
	parameter int MAX_BINS   = MAX_BINS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pdh_in_if.sink               in,
	pdh_out_if.source            out,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);
	cfg_t  cfg_q;
	logic  q_valid;
	item_t q_item;
	logic  q_pop;
	logic  open;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_x    <= BOX_RST;
			cfg_q.box_y    <= BOX_RST;
			cfg_q.box_z    <= BOX_RST;
			cfg_q.bin_size <= BIN_SIZE_RST;
			cfg_q.num_bins <= NUM_BINS_RST;
			cfg_q.slab_lo  <= '0;
			cfg_q.slab_hi  <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_BOX_X:    cfg_q.box_x    <= cfg_data;
				REG_BOX_Y:    cfg_q.box_y    <= cfg_data;
				REG_BOX_Z:    cfg_q.box_z    <= cfg_data;
				REG_BIN_SIZE: cfg_q.bin_size <= cfg_data;
				REG_NUM_BINS: cfg_q.num_bins <= cfg_data[NBINS_W-1:0];
				REG_SLAB_LO:  cfg_q.slab_lo  <= cfg_data;
				REG_SLAB_HI:  cfg_q.slab_hi  <= cfg_data;
				default: ;
			endcase
		end
	end

	pdh_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in),
		.cfg    (cfg_q),
		.open   (open),
		.q_valid(q_valid),
		.q_item (q_item),
		.q_pop  (q_pop)
	);

	pdh_back #(
		.MAX_BINS  (MAX_BINS),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_valid(q_valid),
		.q_item (q_item),
		.q_pop  (q_pop),
		.open   (open),
		.out    (out)
	);
endmodule

/* test/pdh_tb_if.sv */
// Testbench-side note: the channel interfaces come from the RTL files; this file holds shared tb types.
`timescale 1ns / 100ps
package pdh_tb_pkg;
	import pdh_pkg::*;

	typedef struct packed {
		logic                mode;
		logic [COORD_W-1:0]  cx;
		logic [COORD_W-1:0]  cy;
		logic [COORD_W-1:0]  cz;
		logic [COORD_W-1:0]  ox;
		logic [COORD_W-1:0]  oy;
		logic [COORD_W-1:0]  oz;
		logic                cnt;
		logic [RB_W-1:0]     rb;
	} pair_word_t;

	typedef struct packed {
		logic              hit;
		logic [HB_W-1:0]   hit_bin;
		logic [OUT_W-1:0]  bin_count;
		logic [OUT_W-1:0]  center_total;
	} hist_word_t;
endpackage

/* test/tb_top.sv */
// Self-checking bench for the pair distance histogram: directed and random pairs, reads, configs.
`timescale 1ns / 100ps
module tb_top;
	import pdh_pkg::*;
	import pdh_tb_pkg::*;

	localparam int NBINS = MAX_BINS_DEF;

	logic clk;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	pdh_in_if  in_ch();
	pdh_out_if out_ch();

	pair_distance_histogram dut (
		.clk(clk), .arst_n(arst_n), .in(in_ch.sink), .out(out_ch.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// predictor state
	logic [31:0] hist_bins [NBINS];
	logic [31:0] centers_seen;
	logic [19:0] m_box_x, m_box_y, m_box_z, m_bin_size, m_slab_lo, m_slab_hi;
	logic [8:0]  m_num_bins;

	pair_word_t pending_words[$];
	hist_word_t expected_words[$];
	int         errors;
	int         hits_seen;
	int         reads_seen;
	bit         calm;
	bit         feed_done;
	bit         took;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("%0t timeout", $time);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic longint unsigned axis_mag(logic [19:0] c, logic [19:0] o, logic [19:0] b);
		longint d;
		longint bb;
		d  = longint'(o) - longint'(c);
		bb = longint'(b);
		if (2 * d < -bb)
			d += bb;
		else if (2 * d >= bb)
			d -= bb;
		return (d < 0) ? longint'(-d) : longint'(d);
	endfunction

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// predict one result and update the model histogram
	function automatic hist_word_t bin_pair(pair_word_t w);
		hist_word_t      r;
		logic [19:0]     lo, hi;
		longint unsigned ax, ay, az, bs, nb, lim, q, idx;
		r = '0;
		if (w.mode) begin
			r.bin_count = hist_bins[w.rb];
		end else begin
			lo = (m_slab_lo < m_slab_hi) ? m_slab_lo : m_slab_hi;
			hi = (m_slab_lo < m_slab_hi) ? m_slab_hi : m_slab_lo;
			if (m_slab_hi == 0 || (w.cx >= lo && w.cx < hi)) begin
				if (w.cnt && centers_seen != 32'hFFFFFFFF)
					centers_seen++;
				ax = axis_mag(w.cx, w.ox, m_box_x);
				ay = axis_mag(w.cy, w.oy, m_box_y);
				az = axis_mag(w.cz, w.oz, m_box_z);
				bs = (m_bin_size != 0) ? m_bin_size : 1;
				nb = (m_num_bins != 0) ? m_num_bins : 1;
				if (nb > NBINS)
					nb = NBINS;
				lim = bs * (2 * nb - 1);
				q = int_root(4 * (ax * ax + ay * ay + az * az));
				if (q < lim) begin
					idx = (q + bs) / (2 * bs);
					if (idx >= nb)
						idx = nb - 1;
					if (hist_bins[idx] != 32'hFFFFFFFF)
						hist_bins[idx]++;
					r.hit = 1'b1;
					r.hit_bin = idx[7:0];
				end
			end
		end
		r.center_total = centers_seen;
		return r;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [19:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BOX_X:    m_box_x = val;
			REG_BOX_Y:    m_box_y = val;
			REG_BOX_Z:    m_box_z = val;
			REG_BIN_SIZE: m_bin_size = val;
			REG_NUM_BINS: m_num_bins = val[8:0];
			REG_SLAB_LO:  m_slab_lo = val;
			REG_SLAB_HI:  m_slab_hi = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (pending_words.size() == 0 && expected_words.size() == 0);
		repeat (80) @(posedge clk);
	endtask

	function automatic pair_word_t rand_word(bit near);
		pair_word_t w;
		w.mode = ($urandom_range(0, 9) == 0);
		w.cx = 20'($urandom); w.cy = 20'($urandom); w.cz = 20'($urandom);
		w.ox = 20'($urandom); w.oy = 20'($urandom); w.oz = 20'($urandom);
		if (near) begin
			// neighbor close to center, often across the box edge
			w.ox = w.cx + 20'($urandom_range(0, 8000)) - 20'd4000;
			w.oy = w.cy + 20'($urandom_range(0, 8000)) - 20'd4000;
			w.oz = w.cz + 20'($urandom_range(0, 8000)) - 20'd4000;
		end
		w.cnt = 1'($urandom);
		w.rb  = 8'($urandom);
		return w;
	endfunction

	task automatic push_pair(logic [19:0] cx, cy, cz, ox, oy, oz, logic cnt);
		pair_word_t w;
		w = '0;
		w.cx = cx; w.cy = cy; w.cz = cz; w.ox = ox; w.oy = oy; w.oz = oz; w.cnt = cnt;
		pending_words.push_back(w);
	endtask

	task automatic push_read(logic [7:0] rb);
		pair_word_t w;
		w = '0;
		w.mode = 1'b1;
		w.rb = rb;
		pending_words.push_back(w);
	endtask

	task automatic random_phase(int n, bit small_box);
		repeat (n) pending_words.push_back(rand_word(small_box || $urandom_range(0, 3) != 0));
	endtask

	// predict at acceptance and note it for the driver
	always @(posedge clk) begin
		took = arst_n && in_ch.valid && in_ch.ready;
		if (took)
			expected_words.push_back(bin_pair(pending_words[0]));
	end

	// driver: hold a word until accepted, insert idle bursts
	int gap_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			gap_left = 0;
		end else if (!in_ch.valid || took) begin
			if (in_ch.valid)
				void'(pending_words.pop_front());
			if (gap_left > 0) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				gap_left = $urandom_range(0, 5);
				in_ch.valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				pair_word_t w;
				w = pending_words[0];
				in_ch.valid <= 1'b1;
				{in_ch.mode, in_ch.center_x, in_ch.center_y, in_ch.center_z,
				 in_ch.other_x, in_ch.other_y, in_ch.other_z,
				 in_ch.count_center, in_ch.read_bin} <= w;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// sink stalls
	int stall_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 5);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// compare each result word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			hist_word_t got, want;
			got = {out_ch.hit, out_ch.hit_bin, out_ch.bin_count, out_ch.center_total};
			if (expected_words.size() == 0) begin
				errors++;
				$display("%0t unexpected word: %h", $time, got);
			end else begin
				want = expected_words.pop_front();
				if (got.hit) hits_seen++;
				if (got.bin_count != 0) reads_seen++;
				if (got.hit != want.hit)
					$display("%0t hit: expected %0d actual %0d", $time, want.hit, got.hit);
				if (got.hit_bin != want.hit_bin)
					$display("%0t hit_bin: expected %0d actual %0d", $time, want.hit_bin,
						got.hit_bin);
				if (got.bin_count != want.bin_count)
					$display("%0t bin_count: expected %0d actual %0d", $time, want.bin_count,
						got.bin_count);
				if (got.center_total != want.center_total)
					$display("%0t center_total: expected %0d actual %0d", $time,
						want.center_total, got.center_total);
				if (got != want)
					errors++;
			end
		end
	end

	initial begin
		errors = 0; hits_seen = 0; reads_seen = 0; calm = 0; feed_done = 0;
		cfg_we = 1'b0; cfg_idx = REG_BOX_X; cfg_data = '0;
		in_ch.valid = 1'b0; in_ch.mode = 1'b0; in_ch.center_x = '0; in_ch.center_y = '0;
		in_ch.center_z = '0; in_ch.other_x = '0; in_ch.other_y = '0; in_ch.other_z = '0;
		in_ch.count_center = 1'b0; in_ch.read_bin = '0;
		out_ch.ready = 1'b0;
		foreach (hist_bins[i]) hist_bins[i] = '0;
		centers_seen = '0;
		m_box_x = BOX_RST; m_box_y = BOX_RST; m_box_z = BOX_RST;
		m_bin_size = BIN_SIZE_RST; m_num_bins = NUM_BINS_RST;
		m_slab_lo = '0; m_slab_hi = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset config, extremes of fields
		push_pair(20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 1'b1);
		push_pair(20'd0, 20'd0, 20'd0, 20'd512, 20'd0, 20'd0, 1'b1);
		push_pair(20'd0, 20'd0, 20'd0, 20'd511, 20'd0, 20'd0, 1'b0);
		push_pair(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'd0, 20'd0, 20'd0, 1'b1);
		push_pair(20'd0, 20'd0, 20'd0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b0);
		push_pair(20'd0, 20'd0, 20'd0, 20'd261000, 20'd0, 20'd0, 1'b1);
		push_pair(20'd0, 20'd0, 20'd0, 20'd400000, 20'd400000, 20'd0, 1'b0);
		push_read(8'd0); push_read(8'd1); push_read(8'd255); push_read(8'd254);
		drain();

		// tiny boxes, single bin, zero bin size, slab on
		write_reg(REG_BOX_X, 20'd0); write_reg(REG_BOX_Y, 20'd1);
		write_reg(REG_BOX_Z, 20'd3000);
		write_reg(REG_BIN_SIZE, 20'd0); write_reg(REG_NUM_BINS, 20'd0);
		write_reg(REG_SLAB_LO, 20'hFFFFF); write_reg(REG_SLAB_HI, 20'd100);
		push_pair(20'd99, 20'd0, 20'd0, 20'd99, 20'd5, 20'd1500, 1'b1);
		push_pair(20'd100, 20'd0, 20'd0, 20'd100, 20'd0, 20'd0, 1'b1);
		push_pair(20'hFFFFE, 20'd0, 20'd0, 20'hFFFFE, 20'd0, 20'd0, 1'b1);
		push_pair(20'd5, 20'd0, 20'd0, 20'd5, 20'd0, 20'd0, 1'b1);
		push_read(8'd0);
		drain();

		// many bins beyond the maximum, wide hit bins, huge bin size
		write_reg(REG_SLAB_HI, 20'd0); write_reg(REG_NUM_BINS, 20'h1FF);
		write_reg(REG_BIN_SIZE, 20'd1);
		write_reg(REG_BOX_X, 20'd4000); write_reg(REG_BOX_Y, 20'd4000);
		write_reg(REG_BOX_Z, 20'd4000);
		random_phase(500, 1'b1);
		drain();

		write_reg(REG_BIN_SIZE, 20'hFFFFF); write_reg(REG_NUM_BINS, 20'd1);
		write_reg(REG_BOX_X, 20'hFFFFF); write_reg(REG_BOX_Y, 20'd77777);
		write_reg(REG_BOX_Z, 20'd1);
		random_phase(400, 1'b0);
		drain();

		write_reg(REG_BIN_SIZE, 20'd37); write_reg(REG_NUM_BINS, 20'd200);
		write_reg(REG_SLAB_LO, 20'd300000); write_reg(REG_SLAB_HI, 20'd900000);
		write_reg(REG_BOX_X, 20'd9000); write_reg(REG_BOX_Y, 20'd9000);
		write_reg(REG_BOX_Z, 20'd9000);
		random_phase(500, 1'b1);
		drain();

		write_reg(REG_SLAB_HI, 20'd0); write_reg(REG_BIN_SIZE, 20'd64);
		write_reg(REG_NUM_BINS, 20'd256);
		random_phase(300, 1'b1);
		for (int b = 0; b < 256; b += 17) push_read(b[7:0]);
		drain();
		calm = 1;
		random_phase(150, 1'b1);
		drain();

		$display("covered ~1900 words: %0d binned pairs, %0d nonzero bin reads",
			hits_seen, reads_seen);
		if (errors == 0 && expected_words.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

/* files.f */
sv/pdh_pkg.sv
sv/pdh_in_if.sv
sv/pdh_out_if.sv
sv/pdh_ram.sv
sv/pdh_front.sv
sv/pdh_back.sv
sv/pair_distance_histogram.sv
test/pdh_tb_if.sv
test/tb_top.sv
